>>> sv/owcs_pkg.sv
// Package for the orbit weight crossing search: types, codes and the step matrix.
`timescale 1ns / 1ps

package owcs_pkg;

  localparam int WORD_W   = 64;
  localparam int WEIGHT_W = 22;
  localparam int STEPS_W  = 16;
  localparam int COUNT_W  = 17;
  localparam int ONES_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [WORD_W-1:0]   GEN_POLY        = 64'hF4845518B9582A1F;
  localparam logic [WEIGHT_W-1:0] RESET_THRESHOLD = 22'd188766;
  localparam logic [STEPS_W-1:0]  RESET_MAX_STEPS = 16'd32772;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 2'd1;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WORD_W-1:0] matrix_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  crossing_step;
    logic                crossed;
    logic [WEIGHT_W-1:0] final_weight;
  } result_t;

  // Bit k becomes the XOR of bits 0 to k.
  function automatic word_t prefix_xor(word_t v);
    word_t t;
    t = v;
    t = t ^ (t << 1);
    t = t ^ (t << 2);
    t = t ^ (t << 4);
    t = t ^ (t << 8);
    t = t ^ (t << 16);
    t = t ^ (t << 32);
    return t;
  endfunction

  function automatic word_t clmul_lo(word_t a, word_t b);
    word_t r;
    r = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (b[k]) begin
        r = r ^ (a << k);
      end
    end
    return r;
  endfunction

  // Upper product bits of GEN_POLY times m, with the top bit holding the parity of m.
  function automatic word_t clmul_hi_par(word_t m);
    word_t hi;
    hi = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (m[k]) begin
        if (k != 0) begin
          hi = hi ^ (GEN_POLY >> (WORD_W - k));
        end
        hi[WORD_W-1] = ~hi[WORD_W-1];
      end
    end
    return hi;
  endfunction

  // Rows of the combined step matrix: the column matrix followed by the prefix XOR.
  // Both are linear, so the prefix of each column is the column of the product.
  function automatic matrix_t build_step_rows();
    word_t   inv;
    word_t   prod;
    word_t   col;
    matrix_t rows;
    inv  = word_t'(1);
    rows = '0;
    for (int k = 1; k < WORD_W; k++) begin
      prod = clmul_lo(GEN_POLY, inv);
      if (prod[k]) begin
        inv[k] = 1'b1;
      end
    end
    for (int k = 0; k < WORD_W; k++) begin
      col = prefix_xor(clmul_hi_par(clmul_lo(word_t'(1) << k, inv)));
      for (int j = 0; j < WORD_W; j++) begin
        rows[j][k] = col[j];
      end
    end
    return rows;
  endfunction

  localparam matrix_t STEP_ROWS = build_step_rows();

endpackage

>>> sv/owcs_step_unit.sv
// Shared step unit: next prefix word through the constant matrix, and popcount.
`timescale 1ns / 1ps

module owcs_step_unit (
  input  owcs_pkg::word_t                    prefix_word,
  output owcs_pkg::word_t                    next_prefix,
  output logic [owcs_pkg::ONES_W-1:0]        prefix_ones
);

  always_comb begin
    for (int j = 0; j < owcs_pkg::WORD_W; j++) begin
      next_prefix[j] = ^(prefix_word & owcs_pkg::STEP_ROWS[j]);
    end
  end

  assign prefix_ones = owcs_pkg::ONES_W'($countones(prefix_word));

endmodule

>>> sv/owcs_seq.sv
// Sequencer: orbit state, running weight, step count and the result register.
`timescale 1ns / 1ps

module owcs_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  owcs_pkg::word_t                   in_drive,
  input  logic [owcs_pkg::WEIGHT_W-1:0]     threshold,
  input  logic [owcs_pkg::STEPS_W-1:0]      max_steps,
  output logic                              out_valid,
  input  logic                              out_stall,
  output owcs_pkg::result_t                 out_word
);

  owcs_pkg::state_t state_r, state_nxt;
  owcs_pkg::word_t  prefix_r;
  owcs_pkg::word_t  next_prefix;
  logic [owcs_pkg::ONES_W-1:0]   prefix_ones;
  logic [owcs_pkg::WEIGHT_W-1:0] weight_r;
  logic [owcs_pkg::COUNT_W-1:0]  step_r;
  logic                          out_valid_r, out_valid_nxt;
  owcs_pkg::result_t             out_word_r, result_nxt;

  logic [owcs_pkg::WEIGHT_W-1:0] weight_sum;
  logic [owcs_pkg::COUNT_W-1:0]  step_inc;
  logic [owcs_pkg::COUNT_W-1:0]  limit_plus;
  logic at_limit, hit, finish, out_free;
  logic load, advance, emit;

  owcs_step_unit u_step (
    .prefix_word (prefix_r),
    .next_prefix (next_prefix),
    .prefix_ones (prefix_ones)
  );

  assign weight_sum = weight_r + owcs_pkg::WEIGHT_W'(prefix_ones);
  assign step_inc   = step_r + owcs_pkg::COUNT_W'(1);
  assign limit_plus = owcs_pkg::COUNT_W'(max_steps) + owcs_pkg::COUNT_W'(1);
  assign at_limit   = (step_r == owcs_pkg::COUNT_W'(max_steps));
  assign hit        = (weight_sum > threshold);
  assign finish     = (state_r == owcs_pkg::ST_RUN) && (at_limit || hit);
  assign out_free   = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      owcs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = owcs_pkg::ST_RUN;
        end
      end
      owcs_pkg::ST_RUN: begin
        if (finish && out_free) begin
          state_nxt = owcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = owcs_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = 1'b1;
    load     = 1'b0;
    advance  = 1'b0;
    emit     = 1'b0;
    unique case (state_r)
      owcs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        load     = in_valid;
      end
      owcs_pkg::ST_RUN: begin
        advance = !finish;
        emit    = finish && out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // The step limit wins over the weight test: a step beyond the limit is never examined.
  always_comb begin
    if (at_limit) begin
      result_nxt.crossing_step = limit_plus;
      result_nxt.crossed       = 1'b0;
      result_nxt.final_weight  = weight_r;
    end else begin
      result_nxt.crossing_step = step_inc;
      result_nxt.crossed       = 1'b1;
      result_nxt.final_weight  = weight_sum;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= owcs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prefix_r <= owcs_pkg::prefix_xor(in_drive);
      weight_r <= '0;
      step_r   <= '0;
    end else if (advance) begin
      prefix_r <= next_prefix;
      weight_r <= weight_sum;
      step_r   <= step_inc;
    end
    if (emit) begin
      out_word_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> sv/orbit_weight_crossing_search.sv
// Top level of the orbit weight crossing search: configuration registers and sequencer.
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_drive[63:0]
//   out_    | output    | out_valid/out_stall| out_crossing_step[16:0], out_crossed,
//           |           |                    | out_final_weight[21:0]
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index[1:0], cfg_wdata[21:0]
// A word is accepted in an idle cycle; the sequencer then examines one orbit step per cycle
// through the shared matrix and popcount unit. A search that reaches the step limit ends
// with a limit test that examines no further step.
// The input side is stalled from acceptance until the result enters the output register.
// While that register holds a stalled result the sequencer waits on its last step; the
// next word is accepted while the latest result waits.
// Reset is synchronous and restores both registers to their defaults.
`timescale 1ns / 1ps

module orbit_weight_crossing_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [owcs_pkg::WORD_W-1:0]        in_drive,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [owcs_pkg::COUNT_W-1:0]       out_crossing_step,
  output logic                               out_crossed,
  output logic [owcs_pkg::WEIGHT_W-1:0]      out_final_weight,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [owcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [owcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [owcs_pkg::WEIGHT_W-1:0] threshold_r;
  logic [owcs_pkg::STEPS_W-1:0]  max_steps_r;
  owcs_pkg::result_t             result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= owcs_pkg::RESET_THRESHOLD;
      max_steps_r <= owcs_pkg::RESET_MAX_STEPS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        owcs_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata[owcs_pkg::WEIGHT_W-1:0];
        owcs_pkg::CFG_MAX_STEPS: max_steps_r <= cfg_wdata[owcs_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  owcs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_drive  (in_drive),
    .threshold (threshold_r),
    .max_steps (max_steps_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (result)
  );

  assign out_crossing_step = result.crossing_step;
  assign out_crossed       = result.crossed;
  assign out_final_weight  = result.final_weight;

endmodule

>>> sv/owcs_checker.sv
// Port-level checks for the orbit weight crossing search, bound to the top level.
`timescale 1ns / 1ps

module owcs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [owcs_pkg::COUNT_W-1:0]       out_crossing_step,
  input logic                               out_crossed,
  input logic [owcs_pkg::WEIGHT_W-1:0]      out_final_weight
);

  // A result word that is held back must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crossing_step)
      && $stable(out_crossed) && $stable(out_final_weight))
    else $error("held result word changed");

  // Once a word is taken the input side is busy with it in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a word");

  // Steps count from one, so a reported step is never zero.
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_crossing_step != '0)
    else $error("zero crossing step reported");

  // A crossing means the weight exceeded a threshold of at least zero.
  a_crossed_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crossed |-> out_final_weight != '0)
    else $error("crossing reported with zero weight");

endmodule

bind orbit_weight_crossing_search owcs_checker u_owcs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_crossing_step (out_crossing_step),
  .out_crossed       (out_crossed),
  .out_final_weight  (out_final_weight)
);
